// ----- src/dsl_lex_pkg.sv -----
package dsl_lex_pkg;

  localparam int MAX_RES = 4;
  localparam int IDX_W   = $clog2(MAX_RES);
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  // event codes
  localparam logic [1:0] EV_CHAR = 2'd0;
  localparam logic [1:0] EV_END  = 2'd1;
  localparam logic [1:0] EV_ERR  = 2'd2;
  localparam logic [1:0] EV_EOI  = 2'd3;

  // token kinds
  localparam logic [2:0] K_IDENT  = 3'd0;
  localparam logic [2:0] K_NUMBER = 3'd1;
  localparam logic [2:0] K_ASSIGN = 3'd2;
  localparam logic [2:0] K_EQUAL  = 3'd3;
  localparam logic [2:0] K_MINUS  = 3'd4;
  localparam logic [2:0] K_PUNCT  = 3'd5;

  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_NL    = 8'h0a;

  localparam logic [31:0] LINE_MAX = 32'hffff_ffff;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_res;
    logic [2:0]  kind;
    logic [7:0]  char_value;
    logic [31:0] line_number;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [2:0] kind;
    logic [7:0] char_value;
  } res_ent_t;

  // results of one scanned item, handed to the output buffer
  typedef struct packed {
    res_ent_t [MAX_RES-1:0] ent;
    logic [CNT_W-1:0]       cnt;
    logic [31:0]            line;
  } scan_grp_t;

  function automatic res_ent_t mk_ent(logic [1:0] ev, logic [2:0] k, logic [7:0] c);
    res_ent_t e;
    e.event_res  = ev;
    e.kind       = k;
    e.char_value = c;
    return e;
  endfunction

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return c == 8'h7c || c == 8'h2f || c == 8'h3e || c == 8'h26 || c == 8'h25 ||
           c == 8'h28 || c == 8'h29 || c == 8'h2a || c == 8'h2b || c == 8'h7b ||
           c == 8'h7d || c == 8'h2e || c == 8'h5b || c == 8'h5d || c == 8'h2c ||
           c == 8'h3b || c == 8'h3c;
  endfunction

endpackage

// ----- src/dsl_lex_scan.sv -----
module dsl_lex_scan import dsl_lex_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  logic      take,
  output scan_grp_t grp
);

  typedef enum logic [2:0] {M_IDLE, M_IDENT, M_NUMBER, M_EQ, M_MINUS} mode_t;

  mode_t       mode_r, mode_nxt, fr_mode;
  logic [31:0] line_r, line_nxt, fr_line;

  res_ent_t [2:0] pre;
  logic [1:0]     pcnt;
  res_ent_t [1:0] fr;
  logic [1:0]     fcnt;
  logic           run_fresh;
  logic [7:0]     c;

  assign c = in_item.ch;

  // scan c as the start of a new token
  always_comb begin
    fr      = '0;
    fcnt    = 2'd0;
    fr_mode = M_IDLE;
    fr_line = line_r;
    if (is_space(c)) begin
      if (c == CH_NL && line_r != LINE_MAX) fr_line = line_r + 32'd1;
    end else if (is_letter(c)) begin
      fr[0]   = mk_ent(EV_CHAR, K_IDENT, c);
      fcnt    = 2'd1;
      fr_mode = M_IDENT;
    end else if (is_digit(c)) begin
      fr[0]   = mk_ent(EV_CHAR, K_NUMBER, c);
      fcnt    = 2'd1;
      fr_mode = M_NUMBER;
    end else if (c == CH_EQ) begin
      fr_mode = M_EQ;
    end else if (c == CH_MINUS) begin
      fr_mode = M_MINUS;
    end else if (is_punct(c)) begin
      fr[0] = mk_ent(EV_CHAR, K_PUNCT, c);
      fr[1] = mk_ent(EV_END, K_PUNCT, 8'd0);
      fcnt  = 2'd2;
    end else begin
      fr[0] = mk_ent(EV_ERR, K_IDENT, c);
      fcnt  = 2'd1;
    end
  end

  // close or extend the pending token
  always_comb begin
    pre       = '0;
    pcnt      = 2'd0;
    run_fresh = 1'b0;
    mode_nxt  = mode_r;
    if (in_item.end_of_input) begin
      mode_nxt = M_IDLE;
      unique case (mode_r)
        M_IDENT: begin
          pre[0] = mk_ent(EV_END, K_IDENT, 8'd0);
          pre[1] = mk_ent(EV_EOI, K_IDENT, 8'd0);
          pcnt   = 2'd2;
        end
        M_NUMBER: begin
          pre[0] = mk_ent(EV_END, K_NUMBER, 8'd0);
          pre[1] = mk_ent(EV_EOI, K_IDENT, 8'd0);
          pcnt   = 2'd2;
        end
        M_EQ: begin
          pre[0] = mk_ent(EV_CHAR, K_ASSIGN, CH_EQ);
          pre[1] = mk_ent(EV_END, K_ASSIGN, 8'd0);
          pre[2] = mk_ent(EV_EOI, K_IDENT, 8'd0);
          pcnt   = 2'd3;
        end
        M_MINUS: begin
          pre[0] = mk_ent(EV_CHAR, K_MINUS, CH_MINUS);
          pre[1] = mk_ent(EV_END, K_MINUS, 8'd0);
          pre[2] = mk_ent(EV_EOI, K_IDENT, 8'd0);
          pcnt   = 2'd3;
        end
        default: begin
          pre[0] = mk_ent(EV_EOI, K_IDENT, 8'd0);
          pcnt   = 2'd1;
        end
      endcase
    end else begin
      unique case (mode_r)
        M_IDENT: begin
          pcnt = 2'd1;
          if (is_letter(c) || is_digit(c)) begin
            pre[0] = mk_ent(EV_CHAR, K_IDENT, c);
          end else begin
            pre[0]    = mk_ent(EV_END, K_IDENT, 8'd0);
            run_fresh = 1'b1;
          end
        end
        M_NUMBER: begin
          pcnt = 2'd1;
          if (is_digit(c) || c == CH_DOT) begin
            pre[0] = mk_ent(EV_CHAR, K_NUMBER, c);
          end else begin
            pre[0]    = mk_ent(EV_END, K_NUMBER, 8'd0);
            run_fresh = 1'b1;
          end
        end
        M_EQ: begin
          if (c == CH_EQ) begin
            pre[0]   = mk_ent(EV_CHAR, K_EQUAL, CH_EQ);
            pre[1]   = mk_ent(EV_CHAR, K_EQUAL, CH_EQ);
            pre[2]   = mk_ent(EV_END, K_EQUAL, 8'd0);
            pcnt     = 2'd3;
            mode_nxt = M_IDLE;
          end else begin
            pre[0]    = mk_ent(EV_CHAR, K_ASSIGN, CH_EQ);
            pre[1]    = mk_ent(EV_END, K_ASSIGN, 8'd0);
            pcnt      = 2'd2;
            run_fresh = 1'b1;
          end
        end
        M_MINUS: begin
          pcnt = 2'd2;
          if (is_digit(c)) begin
            pre[0]   = mk_ent(EV_CHAR, K_NUMBER, CH_MINUS);
            pre[1]   = mk_ent(EV_CHAR, K_NUMBER, c);
            mode_nxt = M_NUMBER;
          end else begin
            pre[0]    = mk_ent(EV_CHAR, K_MINUS, CH_MINUS);
            pre[1]    = mk_ent(EV_END, K_MINUS, 8'd0);
            run_fresh = 1'b1;
          end
        end
        default: run_fresh = 1'b1;
      endcase
    end
    if (run_fresh) mode_nxt = fr_mode;
  end

  assign line_nxt = run_fresh ? fr_line : line_r;

  // append the fresh-scan results behind the pending-token results
  always_comb begin
    grp.ent    = '0;
    grp.ent[0] = pre[0];
    grp.ent[1] = pre[1];
    grp.ent[2] = pre[2];
    grp.cnt    = CNT_W'(pcnt);
    grp.line   = line_r;
    if (run_fresh) begin
      grp.cnt = CNT_W'(pcnt) + CNT_W'(fcnt);
      case (pcnt)
        2'd0: begin
          grp.ent[0] = fr[0];
          grp.ent[1] = fr[1];
        end
        2'd1: begin
          grp.ent[1] = fr[0];
          grp.ent[2] = fr[1];
        end
        2'd2: begin
          grp.ent[2] = fr[0];
          grp.ent[3] = fr[1];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      line_r <= 32'd1;
    end else if (take) begin
      mode_r <= mode_nxt;
      line_r <= line_nxt;
    end
  end

endmodule

// ----- src/dsl_lex_obuf.sv -----
module dsl_lex_obuf import dsl_lex_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  scan_grp_t grp,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      take,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  res_ent_t [MAX_RES-1:0] ent_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [IDX_W-1:0]       idx_r;
  logic [31:0]            line_r;
  logic                   valid_r;
  logic                   last_one;
  logic                   free;

  assign last_one = (CNT_W'(idx_r) + CNT_W'(1)) == cnt_r;
  // room for a new group once the final result of the current one transfers
  assign free     = !valid_r || (last_one && !out_stall);
  assign in_stall = !free;
  assign take     = in_valid && free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
      idx_r   <= '0;
    end else if (take) begin
      valid_r <= grp.cnt != '0;
      cnt_r   <= grp.cnt;
      idx_r   <= '0;
    end else if (valid_r && !out_stall) begin
      if (last_one) valid_r <= 1'b0;
      else          idx_r   <= idx_r + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ent_r  <= grp.ent;
      line_r <= grp.line;
    end
  end

  assign out_valid            = valid_r;
  assign out_item.event_res   = ent_r[idx_r].event_res;
  assign out_item.kind        = ent_r[idx_r].kind;
  assign out_item.char_value  = ent_r[idx_r].char_value;
  assign out_item.line_number = line_r;
  assign out_item.last        = last_one;

endmodule

// ----- src/dsl_lexical_scanner_unit.sv -----
// channel | direction | handshake            | payload
// in_     | input     | in_valid / in_stall  | in_item_t  (ch, end_of_input)
// out_    | output    | out_valid / out_stall| out_item_t (event, kind, char, line, last)
//
// An item yields n results (n from 0 to 4), which the output presents in turn;
// single-result and resultless items transfer at one per cycle while out_stall is low.
// The four-entry result buffer sets the rate, draining a result a cycle unless stalled.
// Results appear in the cycle after the item transfers.
// Reset (rst_n low, synchronous) empties the buffer, sets line to one, mode to idle.
// out_stall holds the current result; in_stall rises while results remain queued.
module dsl_lexical_scanner_unit import dsl_lex_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  scan_grp_t grp;
  logic      take;

  dsl_lex_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .take    (take),
    .grp     (grp)
  );

  dsl_lex_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .grp       (grp),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ----- src/dsl_lex_chk.sv -----
module dsl_lex_chk import dsl_lex_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input item changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  a_group_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_item.last |=> out_valid)
    else $error("result group broken before last");

  a_eoi_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.event_res == EV_EOI |-> out_item.last)
    else $error("end of input not last result");

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind dsl_lexical_scanner_unit dsl_lex_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

// ----- tb/tb_top.sv -----
module tb_top;
  import dsl_lex_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int HOLD_LEN    = 48;
  localparam logic [2:0] KIND_NONE = 3'd0;

  localparam logic [7:0] PUNCT_SET [17] = '{"|", "/", ">", "&", "%", "(", ")", "*", "+",
                                            "{", "}", ".", "[", "]", ",", ";", "<"};
  localparam logic [7:0] BLANK_SET [5] = '{8'h20, 8'h09, 8'h0b, 8'h0c, 8'h0d};

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_IDENT,
    SCAN_NUM,
    SCAN_EQ,
    SCAN_MINUS
  } scan_mode_e;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } stim_row_t;

  localparam out_item_t NO_WANT = '0;

  // rows with a typed result are checked against that value alone
  localparam stim_row_t DIR_TAB [25] = '{
    '{'{8'h00, 1'b0}, 1'b1, '{EV_ERR, KIND_NONE, 8'h00, 32'd1, 1'b1}},
    '{'{8'hff, 1'b0}, 1'b1, '{EV_ERR, KIND_NONE, 8'hff, 32'd1, 1'b1}},
    '{'{8'h80, 1'b0}, 1'b1, '{EV_ERR, KIND_NONE, 8'h80, 32'd1, 1'b1}},
    '{'{8'ha5, 1'b1}, 1'b1, '{EV_EOI, KIND_NONE, 8'h00, 32'd1, 1'b1}},
    '{'{"a", 1'b0}, 1'b0, NO_WANT},
    '{'{"Z", 1'b0}, 1'b0, NO_WANT},
    '{'{"9", 1'b0}, 1'b0, NO_WANT},
    '{'{8'h09, 1'b0}, 1'b0, NO_WANT},
    '{'{CH_MINUS, 1'b0}, 1'b0, NO_WANT},
    '{'{"7", 1'b0}, 1'b0, NO_WANT},
    '{'{CH_DOT, 1'b0}, 1'b0, NO_WANT},
    '{'{CH_NL, 1'b0}, 1'b0, NO_WANT},
    '{'{CH_EQ, 1'b0}, 1'b0, NO_WANT},
    '{'{CH_EQ, 1'b0}, 1'b0, NO_WANT},
    '{'{CH_EQ, 1'b0}, 1'b0, NO_WANT},
    '{'{"x", 1'b0}, 1'b0, NO_WANT},
    '{'{CH_MINUS, 1'b0}, 1'b0, NO_WANT},
    '{'{"(", 1'b0}, 1'b0, NO_WANT},
    '{'{CH_EQ, 1'b0}, 1'b0, NO_WANT},
    '{'{8'h00, 1'b1}, 1'b0, NO_WANT},
    '{'{CH_MINUS, 1'b0}, 1'b0, NO_WANT},
    '{'{8'h00, 1'b1}, 1'b0, NO_WANT},
    '{'{"0", 1'b0}, 1'b0, NO_WANT},
    '{'{8'h00, 1'b1}, 1'b0, NO_WANT},
    '{'{"<", 1'b0}, 1'b0, NO_WANT}
  };

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  logic      in_typed = 1'b0;
  out_item_t in_want = '0;
  logic      calm = 1'b0;
  int        acc_cnt = 0;

  stim_row_t stim_q [$];
  stim_row_t tx_row;
  int        tx_gap = 0;
  int        rx_gap = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;

  out_item_t  tok_exp_q [$];
  out_item_t  tok_grp_q [$];
  scan_mode_e lex_mode = SCAN_IDLE;
  logic [31:0] line_cnt = 32'd1;
  int         bad_cnt = 0;
  int         stuck_cycles = 0;
  bit         moved;

  always #4 clk = ~clk;

  dsl_lexical_scanner_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  function automatic bit alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit numeral(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic bit punct_char(logic [7:0] c);
    foreach (PUNCT_SET[i]) if (c == PUNCT_SET[i]) return 1'b1;
    return 1'b0;
  endfunction

  task automatic add_tok(logic [1:0] ev, logic [2:0] k, logic [7:0] c);
    out_item_t r;
    r.event_res   = ev;
    r.kind        = k;
    r.char_value  = c;
    r.line_number = line_cnt;
    r.last        = 1'b0;
    tok_grp_q.push_back(r);
  endtask

  // start a new token, or skip a blank, with nothing pending
  task automatic scan_fresh(logic [7:0] c);
    if (blank(c)) begin
      if (c == CH_NL && line_cnt != LINE_MAX) line_cnt = line_cnt + 1;
      lex_mode = SCAN_IDLE;
    end else if (alpha(c)) begin
      add_tok(EV_CHAR, K_IDENT, c);
      lex_mode = SCAN_IDENT;
    end else if (numeral(c)) begin
      add_tok(EV_CHAR, K_NUMBER, c);
      lex_mode = SCAN_NUM;
    end else if (c == CH_EQ) begin
      lex_mode = SCAN_EQ;
    end else if (c == CH_MINUS) begin
      lex_mode = SCAN_MINUS;
    end else if (punct_char(c)) begin
      add_tok(EV_CHAR, K_PUNCT, c);
      add_tok(EV_END, K_PUNCT, 8'h00);
      lex_mode = SCAN_IDLE;
    end else begin
      add_tok(EV_ERR, KIND_NONE, c);
      lex_mode = SCAN_IDLE;
    end
  endtask

  task automatic lex_predict(in_item_t it);
    logic [7:0] c;
    out_item_t  tail;
    c = it.ch;
    tok_grp_q.delete();
    if (it.end_of_input) begin
      case (lex_mode)
        SCAN_IDENT: add_tok(EV_END, K_IDENT, 8'h00);
        SCAN_NUM:   add_tok(EV_END, K_NUMBER, 8'h00);
        SCAN_EQ: begin
          add_tok(EV_CHAR, K_ASSIGN, CH_EQ);
          add_tok(EV_END, K_ASSIGN, 8'h00);
        end
        SCAN_MINUS: begin
          add_tok(EV_CHAR, K_MINUS, CH_MINUS);
          add_tok(EV_END, K_MINUS, 8'h00);
        end
        default: ;
      endcase
      add_tok(EV_EOI, KIND_NONE, 8'h00);
      lex_mode = SCAN_IDLE;
    end else begin
      case (lex_mode)
        SCAN_IDENT: begin
          if (alpha(c) || numeral(c)) begin
            add_tok(EV_CHAR, K_IDENT, c);
          end else begin
            add_tok(EV_END, K_IDENT, 8'h00);
            scan_fresh(c);
          end
        end
        SCAN_NUM: begin
          if (numeral(c) || c == CH_DOT) begin
            add_tok(EV_CHAR, K_NUMBER, c);
          end else begin
            add_tok(EV_END, K_NUMBER, 8'h00);
            scan_fresh(c);
          end
        end
        SCAN_EQ: begin
          if (c == CH_EQ) begin
            add_tok(EV_CHAR, K_EQUAL, CH_EQ);
            add_tok(EV_CHAR, K_EQUAL, CH_EQ);
            add_tok(EV_END, K_EQUAL, 8'h00);
            lex_mode = SCAN_IDLE;
          end else begin
            add_tok(EV_CHAR, K_ASSIGN, CH_EQ);
            add_tok(EV_END, K_ASSIGN, 8'h00);
            scan_fresh(c);
          end
        end
        SCAN_MINUS: begin
          if (numeral(c)) begin
            add_tok(EV_CHAR, K_NUMBER, CH_MINUS);
            add_tok(EV_CHAR, K_NUMBER, c);
            lex_mode = SCAN_NUM;
          end else begin
            add_tok(EV_CHAR, K_MINUS, CH_MINUS);
            add_tok(EV_END, K_MINUS, 8'h00);
            scan_fresh(c);
          end
        end
        default: scan_fresh(c);
      endcase
    end
    if (tok_grp_q.size() > 0) begin
      tail = tok_grp_q.pop_back();
      tail.last = 1'b1;
      tok_grp_q.push_back(tail);
    end
  endtask

  task automatic check_token(out_item_t got);
    out_item_t want;
    if (tok_exp_q.size() == 0) begin
      bad_cnt++;
      if (bad_cnt <= 10)
        $display("unexpected result: ev=%0d kind=%0d ch=%02h line=%0d last=%0d",
                 got.event_res, got.kind, got.char_value, got.line_number, got.last);
    end else begin
      want = tok_exp_q.pop_front();
      if (got.event_res !== want.event_res || got.kind !== want.kind ||
          got.char_value !== want.char_value || got.line_number !== want.line_number ||
          got.last !== want.last) begin
        bad_cnt++;
        if (bad_cnt <= 10) begin
          $write("mismatch: exp ev=%0d kind=%0d ch=%02h line=%0d last=%0d, ",
                 want.event_res, want.kind, want.char_value, want.line_number, want.last);
          $display("got ev=%0d kind=%0d ch=%02h line=%0d last=%0d",
                   got.event_res, got.kind, got.char_value, got.line_number, got.last);
        end
      end
    end
  endtask

  task automatic push_ch(logic [7:0] c, logic eoi = 1'b0);
    stim_row_t r;
    r.item.ch           = c;
    r.item.end_of_input = eoi;
    r.typed             = 1'b0;
    r.want              = NO_WANT;
    stim_q.push_back(r);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? "A" : "a";
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return "0" + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_blank();
    if ($urandom_range(0, 9) < 4) return CH_NL;
    return BLANK_SET[$urandom_range(0, 4)];
  endfunction

  // mostly well-formed tokens with random content, plus noise bytes and stream ends
  task automatic gen_stream(int target);
    int base;
    int pick;
    base = stim_q.size();
    while (stim_q.size() - base < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        push_ch(rand_letter());
        repeat ($urandom_range(0, 6))
          push_ch($urandom_range(0, 2) == 0 ? rand_digit() : rand_letter());
      end else if (pick < 48) begin
        if ($urandom_range(0, 2) == 0) push_ch(CH_MINUS);
        push_ch(rand_digit());
        repeat ($urandom_range(0, 5))
          push_ch($urandom_range(0, 3) == 0 ? CH_DOT : rand_digit());
      end else if (pick < 55) begin
        push_ch(CH_EQ);
      end else if (pick < 61) begin
        push_ch(CH_EQ);
        push_ch(CH_EQ);
      end else if (pick < 66) begin
        push_ch(CH_MINUS);
      end else if (pick < 78) begin
        push_ch(PUNCT_SET[$urandom_range(0, 16)]);
      end else if (pick < 84) begin
        push_ch(8'($urandom_range(0, 255)));
      end else if (pick < 88) begin
        push_ch(8'($urandom_range(0, 255)), 1'b1);
      end else begin
        repeat ($urandom_range(1, 3)) push_ch(rand_blank());
      end
      if ($urandom_range(0, 1) == 0) push_ch(rand_blank());
    end
  endtask

  // sender: hold the payload until the transfer, then advance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (stim_q.size() > 0) begin
        tx_row = stim_q.pop_front();
        in_item  <= tx_row.item;
        in_typed <= tx_row.typed;
        in_want  <= tx_row.want;
        in_valid <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) tx_gap = $urandom_range(1, 15);
      end else begin
        in_valid <= 1'b0;
      end
    end
    calm <= (stim_q.size() < 60);
  end

  // receiver: random stall bursts plus one long hold-off to back up the block
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (!hold_done && acc_cnt >= 100) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!calm && $urandom_range(0, 9) == 0) rx_gap = $urandom_range(1, 15);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      lex_mode = SCAN_IDLE;
      line_cnt = 32'd1;
      stuck_cycles = 0;
    end else begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        acc_cnt <= acc_cnt + 1;
        lex_predict(in_item);
        if (in_typed) tok_exp_q.push_back(in_want);
        else foreach (tok_grp_q[i]) tok_exp_q.push_back(tok_grp_q[i]);
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        check_token(out_item);
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
    end
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(negedge clk);
    $display("dsl_lexical_scanner_unit verification failed");
    $finish;
  end

  initial begin
    foreach (DIR_TAB[i]) stim_q.push_back(DIR_TAB[i]);
    gen_stream(252);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk); while (stim_q.size() != 0 || in_valid || tok_exp_q.size() != 0);
    // drain: catch any stray results after the last expected one
    repeat (20) @(posedge clk);
    if (bad_cnt == 0 && tok_exp_q.size() == 0)
      $display("dsl_lexical_scanner_unit verification clean");
    else
      $display("dsl_lexical_scanner_unit verification failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/dsl_lex_pkg.sv
src/dsl_lex_scan.sv
src/dsl_lex_obuf.sv
src/dsl_lexical_scanner_unit.sv
src/dsl_lex_chk.sv
tb/tb_top.sv
